@@ src/fragment_reorder_reassembly_macros.svh @@
// assertion macros for the fragment reorder and reassembly block
`ifndef FRAGMENT_REORDER_REASSEMBLY_MACROS_SVH
`define FRAGMENT_REORDER_REASSEMBLY_MACROS_SVH

// implication checked on every clock edge outside reset
`define FRR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frr implication check failed");

// next-cycle implication checked outside reset
`define FRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frr next-cycle check failed");

`endif

@@ src/frr_pkg.sv @@
// shared constants, types and state codes of the fragment reassembly block
package frr_pkg;

    localparam int NODE_COUNT            = 16;
    localparam int FRAGMENTS_PER_MESSAGE = 64;
    localparam int MESSAGE_BYTES         = 8192;

    localparam int SRC_W   = $clog2(NODE_COUNT);
    localparam int FRAG_W  = $clog2(FRAGMENTS_PER_MESSAGE);
    localparam int MSG_W   = 16;
    localparam int FNUM_W  = 7;
    localparam int LEN_W   = 11;
    localparam int BYTES_W = 14;
    localparam int SUM_W   = BYTES_W + 1;
    localparam int SLOT_W  = SRC_W + FRAG_W;
    localparam int HELD_W  = LEN_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT
    } state_t;

    // per-source row: expected message, next fragment, bytes placed, held map
    typedef struct packed {
        logic [MSG_W-1:0]                 exp_msg;
        logic [FNUM_W-1:0]                next_frag;
        logic [BYTES_W-1:0]               bytes;
        logic [FRAGMENTS_PER_MESSAGE-1:0] held;
    } src_row_t;

    typedef struct packed {
        logic             en;
        logic [SRC_W-1:0] addr;
        src_row_t         row;
    } src_wr_t;

    localparam src_row_t RESET_ROW = '{
        exp_msg:   MSG_W'(1),
        next_frag: '0,
        bytes:     '0,
        held:      '0
    };

endpackage

@@ src/frr_in_if.sv @@
// fragment descriptor channel
interface frr_in_if;
    import frr_pkg::*;

    logic               valid;
    logic               ready;
    logic [SRC_W-1:0]   source_node;
    logic [MSG_W-1:0]   message_number;
    logic [FNUM_W-1:0]  fragment_number;
    logic [LEN_W-1:0]   fragment_length;
    logic               last_fragment;

    modport source (output valid, source_node, message_number, fragment_number,
                    fragment_length, last_fragment, input ready);
    modport sink (input valid, source_node, message_number, fragment_number,
                  fragment_length, last_fragment, output ready);
endinterface

@@ src/frr_out_if.sv @@
// released fragment channel
interface frr_out_if;
    import frr_pkg::*;

    logic               valid;
    logic               ready;
    logic [SRC_W-1:0]   out_source;
    logic [FRAG_W-1:0]  out_fragment;
    logic [BYTES_W-1:0] byte_offset;
    logic [LEN_W-1:0]   out_length;
    logic               message_done;
    logic [BYTES_W-1:0] message_bytes;
    logic               run_end;

    modport source (output valid, out_source, out_fragment, byte_offset, out_length,
                    message_done, message_bytes, run_end, input ready);
    modport sink (input valid, out_source, out_fragment, byte_offset, out_length,
                  message_done, message_bytes, run_end, output ready);
endinterface

@@ src/frr_ram.sv @@
// generic single-write, single-read synchronous ram with registered read
module frr_ram #(
    parameter int AW = 10,
    parameter int DW = 12
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);
    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ src/frr_src_table.sv @@
// per-source state memory with row valid flags that reset clears
module frr_src_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [frr_pkg::SRC_W-1:0] rd_addr,
    output frr_pkg::src_row_t     rd_row,
    input  frr_pkg::src_wr_t      wr
);
    import frr_pkg::*;

    src_row_t               mem [NODE_COUNT];
    src_row_t               rd_row_reg;
    logic [NODE_COUNT-1:0]  row_ok_reg;
    logic                   rd_ok_reg;

    // row storage
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    // written flags, an unwritten row reads as the reset row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                row_ok_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= row_ok_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_ok_reg ? rd_row_reg : RESET_ROW;
endmodule

@@ src/fragment_reorder_reassembly.sv @@
// top level: fragment reorder and reassembly sequencer
//
// Fragment descriptors enter on the sink channel frag; released fragments
// leave on the source channel result, one word per fragment placed in order.
// An accepted fragment reads its source row, then is dropped, held in the
// fragment ram, or released. A release issues one word per cycle while the
// receiver keeps up, as the held ram is read one fragment ahead. A drain of
// n held fragments issues n+1 words. A fragment that releases nothing
// returns the block to idle straight from the row lookup.
// frag.ready is high only while idle; one fragment is in work at a time.
// The last word of each run carries run_end; message_done marks completion.
// Words sit in an output register, so a stalled receiver stops the drain
// after the current word and nothing is lost.
// Reset clears the control state and marks every source row as unwritten,
// which reads as expected message one, no fragments and no bytes; there is
// no clearing pass. Held fragment data is guarded by the per-source map.
module fragment_reorder_reassembly (
    input logic    clk,
    input logic    rst_n,
    frr_in_if.sink   frag,
    frr_out_if.source result
);
    import frr_pkg::*;

    state_t state_reg, state_next;

    // accepted fragment
    logic [SRC_W-1:0]  src_reg;
    logic [MSG_W-1:0]  msg_reg;
    logic [FNUM_W-1:0] fnum_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              last_reg;

    // run state
    src_row_t          row_reg, row_next;
    logic [FRAG_W-1:0] cur_frag_reg, cur_frag_next;
    logic [LEN_W-1:0]  cur_len_reg, cur_len_next;
    logic              cur_last_reg, cur_last_next;

    // output word
    logic               out_valid_reg, out_valid_next;
    logic [SRC_W-1:0]   o_src_reg, o_src_next;
    logic [FRAG_W-1:0]  o_frag_reg, o_frag_next;
    logic [BYTES_W-1:0] o_off_reg, o_off_next;
    logic [LEN_W-1:0]   o_len_reg, o_len_next;
    logic               o_done_reg, o_done_next;
    logic [BYTES_W-1:0] o_total_reg, o_total_next;
    logic               o_end_reg, o_end_next;

    // memory ports
    src_row_t          tbl_row;
    src_wr_t           tbl_wr;
    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_wr_addr;
    logic [HELD_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [SLOT_W-1:0] ram_rd_addr;
    logic [HELD_W-1:0] ram_rd_data;

    // decision terms
    logic              accept;
    logic              slot_free;
    logic              emit;
    logic [FRAG_W-1:0] f6;
    logic              drop;
    logic [SUM_W-1:0]  arr_sum;
    logic [FNUM_W-1:0] nf1;
    logic [SUM_W-1:0]  run_sum;
    logic [SUM_W-1:0]  next_sum;
    logic              next_held;
    logic              has_next;

    frr_src_table u_tbl (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (frag.source_node),
        .rd_row  (tbl_row),
        .wr      (tbl_wr)
    );

    frr_ram #(.AW(SLOT_W), .DW(HELD_W)) u_held (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign accept    = frag.valid && frag.ready;
    assign slot_free = !out_valid_reg || result.ready;
    assign emit      = (state_reg == S_EMIT) && slot_free;

    // arrival checks against the fetched row
    assign f6   = fnum_reg[FRAG_W-1:0];
    assign drop = (32'(src_reg) >= NODE_COUNT) || (32'(fnum_reg) >= FRAGMENTS_PER_MESSAGE)
               || (msg_reg != tbl_row.exp_msg) || (fnum_reg < tbl_row.next_frag);
    assign arr_sum = SUM_W'(tbl_row.bytes) + SUM_W'(len_reg);

    // drain look-ahead on the held fragment after the current one
    assign nf1       = FNUM_W'(cur_frag_reg) + FNUM_W'(1);
    assign run_sum   = SUM_W'(row_reg.bytes) + SUM_W'(cur_len_reg);
    assign next_sum  = run_sum + SUM_W'(ram_rd_data[HELD_W-1:1]);
    assign next_held = !cur_last_reg && (32'(nf1) < FRAGMENTS_PER_MESSAGE)
                    && row_reg.held[nf1[FRAG_W-1:0]];
    assign has_next  = next_held && (next_sum <= SUM_W'(MESSAGE_BYTES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!drop && (fnum_reg == tbl_row.next_frag)
                    && (arr_sum <= SUM_W'(MESSAGE_BYTES)))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (emit && !has_next)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        row_next       = row_reg;
        cur_frag_next  = cur_frag_reg;
        cur_len_next   = cur_len_reg;
        cur_last_next  = cur_last_reg;
        out_valid_next = out_valid_reg && !result.ready;
        o_src_next     = o_src_reg;
        o_frag_next    = o_frag_reg;
        o_off_next     = o_off_reg;
        o_len_next     = o_len_reg;
        o_done_next    = o_done_reg;
        o_total_next   = o_total_reg;
        o_end_next     = o_end_reg;
        tbl_wr.en      = 1'b0;
        tbl_wr.addr    = src_reg;
        tbl_wr.row     = tbl_row;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = {src_reg, f6};
        ram_wr_data    = {len_reg, last_reg};
        ram_rd_en      = 1'b0;
        ram_rd_addr    = {src_reg, FRAG_W'(fnum_reg + FNUM_W'(1))};
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_LOOK:
            begin
                if (!drop && (fnum_reg > tbl_row.next_frag))
                begin
                    // early fragment: hold it unless the slot is taken
                    if (!tbl_row.held[f6])
                    begin
                        ram_wr_en          = 1'b1;
                        tbl_wr.en          = 1'b1;
                        tbl_wr.row.held[f6] = 1'b1;
                    end
                end
                else if (!drop && (arr_sum <= SUM_W'(MESSAGE_BYTES)))
                begin
                    // in order: start a run and read the next slot ahead
                    row_next      = tbl_row;
                    cur_frag_next = f6;
                    cur_len_next  = len_reg;
                    cur_last_next = last_reg;
                    ram_rd_en     = 1'b1;
                end
            end
            S_EMIT:
            begin
                ram_rd_addr = {src_reg, FRAG_W'(nf1 + FNUM_W'(1))};
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    o_src_next     = src_reg;
                    o_frag_next    = cur_frag_reg;
                    o_off_next     = row_reg.bytes;
                    o_len_next     = cur_len_reg;
                    o_done_next    = cur_last_reg;
                    o_total_next   = cur_last_reg ? BYTES_W'(run_sum) : '0;
                    o_end_next     = !has_next;
                    row_next.bytes     = BYTES_W'(run_sum);
                    row_next.next_frag = nf1;
                    if (next_held)
                    begin
                        row_next.held[nf1[FRAG_W-1:0]] = 1'b0;
                    end
                    if (has_next)
                    begin
                        cur_frag_next = nf1[FRAG_W-1:0];
                        cur_len_next  = ram_rd_data[HELD_W-1:1];
                        cur_last_next = ram_rd_data[0];
                        ram_rd_en     = 1'b1;
                    end
                    else
                    begin
                        // run over: write the row back, cleared on completion
                        tbl_wr.en  = 1'b1;
                        tbl_wr.row = row_next;
                        if (cur_last_reg)
                        begin
                            tbl_wr.row.exp_msg   = row_reg.exp_msg + MSG_W'(1);
                            tbl_wr.row.next_frag = '0;
                            tbl_wr.row.bytes     = '0;
                            tbl_wr.row.held      = '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg  <= frag.source_node;
            msg_reg  <= frag.message_number;
            fnum_reg <= frag.fragment_number;
            len_reg  <= frag.fragment_length;
            last_reg <= frag.last_fragment;
        end
        row_reg      <= row_next;
        cur_frag_reg <= cur_frag_next;
        cur_len_reg  <= cur_len_next;
        cur_last_reg <= cur_last_next;
        o_src_reg    <= o_src_next;
        o_frag_reg   <= o_frag_next;
        o_off_reg    <= o_off_next;
        o_len_reg    <= o_len_next;
        o_done_reg   <= o_done_next;
        o_total_reg  <= o_total_next;
        o_end_reg    <= o_end_next;
    end

    // port drive
    assign frag.ready           = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.out_source    = o_src_reg;
    assign result.out_fragment  = o_frag_reg;
    assign result.byte_offset   = o_off_reg;
    assign result.out_length    = o_len_reg;
    assign result.message_done  = o_done_reg;
    assign result.message_bytes = o_total_reg;
    assign result.run_end       = o_end_reg;

`include "fragment_reorder_reassembly_macros.svh"

    // a completing word always closes its run
    `FRR_ASSERT_IMP(a_done_ends_run, result.valid && result.message_done, result.run_end)
    // the released payload never runs past the message buffer
    `FRR_ASSERT_IMP(a_fits, result.valid,
        (SUM_W'(result.byte_offset) + SUM_W'(result.out_length)) <= SUM_W'(MESSAGE_BYTES))
    // a run that leaves the emit state has just loaded its closing word
    `FRR_ASSERT_NEXT(a_run_closed, (state_reg == S_EMIT) && (state_next == S_IDLE),
        result.valid && result.run_end)
endmodule
